// File: rtl/sgs_pkg.sv
// sgs_pkg: grid geometry, widths, action and state codes for the sandpile grid sweep.
// Used by sgs_ram and sandpile_grid_sweep; depends on nothing.
package sgs_pkg;

  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 64;
  localparam int CELLS      = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int X_W        = $clog2(GRID_COLS);
  localparam int Y_W        = $clog2(GRID_ROWS);

  localparam int HEIGHT_W   = 8;
  localparam int COUNT_W    = 13;
  localparam int COORD_W    = 6;
  localparam int ACTION_W   = 2;

  localparam logic [HEIGHT_W-1:0] TOPPLE_AT  = HEIGHT_W'(4);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_SWEEP = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // neighbor directions, in the order the sweep visits them
  typedef enum logic [1:0] {
    NB_YM = 2'd0,
    NB_YP = 2'd1,
    NB_XM = 2'd2,
    NB_XP = 2'd3
  } nb_dir_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_OP_RD,
    ST_OP_CHK,
    ST_SW_RD,
    ST_SW_CHK,
    ST_SW_NB,
    ST_RESP
  } state_t;

  // one grain more, held at the top
  function automatic logic [HEIGHT_W-1:0] sat_inc(input logic [HEIGHT_W-1:0] h);
    logic [HEIGHT_W-1:0] r;
    r = (h == HEIGHT_MAX) ? h : h + HEIGHT_W'(1);
    return r;
  endfunction

endpackage

// File: rtl/sgs_ram.sv
// sgs_ram: simple dual-port RAM, one write and one registered read port.
// Default geometry from sgs_pkg.
module sgs_ram #(
  parameter int DEPTH = sgs_pkg::CELLS,
  parameter int WIDTH = sgs_pkg::HEIGHT_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sandpile_grid_sweep.sv
// sandpile_grid_sweep: sandpile height grid in one RAM with a read-modify-write sequencer.
// Depends on sgs_pkg and sgs_ram.
//
// Usage
//   Input channel (in_valid / in_stall): one item per transfer, in_action selects
//   add grain, one toppling sweep, read cell or no-op; in_cell_x / in_cell_y address
//   the cell for add and read. Output channel (out_valid / out_stall): exactly one
//   result per item, in order, from an output register.
//   Steps: add and read pass through ST_OP_RD, ST_OP_CHK and ST_RESP before out_valid;
//   an out-of-range add/read or a no-op goes from ST_IDLE straight to ST_RESP. A sweep
//   reads each cell in turn and gives each toppling cell one read-modify-write per
//   in-grid neighbor, all through the single RAM read port.
//   Items are taken one at a time: in_stall is low only while the sequencer is idle.
//   The output register lets the next item be taken while a result waits.
//   Reset: synchronous, active low. After reset a clearing pass writes zero to all
//   CELLS entries, one per cycle; in_stall stays high through it.
//   Stall: a result held by out_stall stays stable; a following item runs to its
//   result and then waits in the sequencer until the output register frees up.
module sandpile_grid_sweep (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sgs_pkg::ACTION_W-1:0] in_action,
  input  logic [sgs_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [sgs_pkg::COORD_W-1:0]  in_cell_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sgs_pkg::HEIGHT_W-1:0] out_cell_height,
  output logic                         out_occupied,
  output logic [sgs_pkg::COUNT_W-1:0]  out_topple_count,
  output logic                         out_out_of_range
);

  localparam int AW = sgs_pkg::ADDR_W;
  localparam int XW = sgs_pkg::X_W;
  localparam int YW = sgs_pkg::Y_W;
  localparam int HW = sgs_pkg::HEIGHT_W;
  localparam int CW = sgs_pkg::COUNT_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(sgs_pkg::CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(sgs_pkg::GRID_ROWS);
  localparam logic [XW-1:0] LAST_X    = XW'(sgs_pkg::GRID_COLS - 1);
  localparam logic [YW-1:0] LAST_Y    = YW'(sgs_pkg::GRID_ROWS - 1);

  // sequencer state
  sgs_pkg::state_t  state_r,  state_nxt;
  sgs_pkg::action_t act_r,    act_nxt;
  logic [AW-1:0]    addr_r,   addr_nxt;     // clear pointer, op cell, or sweep cell
  logic [XW-1:0]    x_r,      x_nxt;
  logic [YW-1:0]    y_r,      y_nxt;
  logic [AW-1:0]    nb_addr_r, nb_addr_nxt; // neighbor under read-modify-write
  logic [3:0]       nb_pend_r, nb_pend_nxt; // neighbors still to visit
  logic [CW-1:0]    count_r,  count_nxt;
  logic [HW-1:0]    res_height_r, res_height_nxt;
  logic             res_oor_r,    res_oor_nxt;

  // output register
  logic             out_valid_r;
  logic [HW-1:0]    out_height_r;
  logic             out_occ_r;
  logic [CW-1:0]    out_count_r;
  logic             out_oor_r;
  logic             out_load;

  // RAM port signals
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [HW-1:0]    ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [HW-1:0]    ram_rdata;

  // decode of the incoming item
  sgs_pkg::action_t in_act;
  logic [AW-1:0]    in_index;
  logic             in_oor;

  // sweep helpers
  logic [3:0]       nb_mask;
  logic [3:0]       pick_src;
  sgs_pkg::nb_dir_t pick_dir;
  logic [3:0]       pick_bit;
  logic [AW-1:0]    pick_addr;
  logic             last_cell;
  logic [XW-1:0]    x_step;
  logic [YW-1:0]    y_step;
  logic [HW-1:0]    op_height;
  logic [CW-1:0]    count_inc;

  sgs_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_act   = sgs_pkg::action_t'(in_action);
  assign in_oor   = (int'(in_cell_x) >= sgs_pkg::GRID_COLS) ||
                    (int'(in_cell_y) >= sgs_pkg::GRID_ROWS);
  assign in_index = AW'(in_cell_x) * ROW_STEP + AW'(in_cell_y);

  // neighbors inside the grid: {x+1, x-1, y+1, y-1}
  assign nb_mask = {x_r != LAST_X, x_r != '0, y_r != LAST_Y, y_r != '0};

  assign last_cell = (x_r == LAST_X) && (y_r == LAST_Y);
  assign y_step    = (y_r == LAST_Y) ? '0 : y_r + YW'(1);
  assign x_step    = (y_r == LAST_Y) ? x_r + XW'(1) : x_r;
  assign count_inc = (count_r == sgs_pkg::COUNT_MAX) ? count_r : count_r + CW'(1);
  assign op_height = (act_r == sgs_pkg::ACT_ADD) ? sgs_pkg::sat_inc(ram_rdata) : ram_rdata;

  // first neighbor still owed a grain
  always_comb begin
    pick_src = (state_r == sgs_pkg::ST_SW_NB) ? nb_pend_r : nb_mask;
    if (pick_src[0]) begin
      pick_dir = sgs_pkg::NB_YM;
    end else if (pick_src[1]) begin
      pick_dir = sgs_pkg::NB_YP;
    end else if (pick_src[2]) begin
      pick_dir = sgs_pkg::NB_XM;
    end else begin
      pick_dir = sgs_pkg::NB_XP;
    end
    pick_bit = 4'b0001 << pick_dir;
    unique case (pick_dir)
      sgs_pkg::NB_YM: pick_addr = addr_r - AW'(1);
      sgs_pkg::NB_YP: pick_addr = addr_r + AW'(1);
      sgs_pkg::NB_XM: pick_addr = addr_r - ROW_STEP;
      sgs_pkg::NB_XP: pick_addr = addr_r + ROW_STEP;
      default:        pick_addr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgs_pkg::ST_CLR;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    nb_addr_r    <= nb_addr_nxt;
    nb_pend_r    <= nb_pend_nxt;
    count_r      <= count_nxt;
    res_height_r <= res_height_nxt;
    res_oor_r    <= res_oor_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_nxt       = addr_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    nb_addr_nxt    = nb_addr_r;
    nb_pend_nxt    = nb_pend_r;
    count_nxt      = count_r;
    res_height_nxt = res_height_r;
    res_oor_nxt    = res_oor_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;
    in_stall       = 1'b1;
    out_load       = 1'b0;

    unique case (state_r)
      sgs_pkg::ST_CLR: begin
        ram_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = sgs_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      sgs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          act_nxt        = in_act;
          addr_nxt       = in_index;
          count_nxt      = '0;
          res_height_nxt = '0;
          res_oor_nxt    = 1'b0;
          unique case (in_act) inside
            sgs_pkg::ACT_SWEEP: begin
              addr_nxt  = '0;
              x_nxt     = '0;
              y_nxt     = '0;
              state_nxt = sgs_pkg::ST_SW_RD;
            end
            sgs_pkg::ACT_ADD, sgs_pkg::ACT_READ: begin
              if (in_oor) begin
                res_oor_nxt = 1'b1;
                state_nxt   = sgs_pkg::ST_RESP;
              end else begin
                state_nxt = sgs_pkg::ST_OP_RD;
              end
            end
            default: begin
              state_nxt = sgs_pkg::ST_RESP;
            end
          endcase
        end
      end

      sgs_pkg::ST_OP_RD: begin
        ram_re    = 1'b1;
        state_nxt = sgs_pkg::ST_OP_CHK;
      end

      sgs_pkg::ST_OP_CHK: begin
        ram_we         = (act_r == sgs_pkg::ACT_ADD);
        ram_wdata      = op_height;
        res_height_nxt = op_height;
        state_nxt      = sgs_pkg::ST_RESP;
      end

      sgs_pkg::ST_SW_RD: begin
        ram_re    = 1'b1;
        state_nxt = sgs_pkg::ST_SW_CHK;
      end

      sgs_pkg::ST_SW_CHK: begin
        if (ram_rdata >= sgs_pkg::TOPPLE_AT) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata - sgs_pkg::TOPPLE_AT;
          count_nxt = count_inc;
          if (nb_mask != '0) begin
            ram_re      = 1'b1;
            ram_raddr   = pick_addr;
            nb_addr_nxt = pick_addr;
            nb_pend_nxt = nb_mask & ~pick_bit;
            state_nxt   = sgs_pkg::ST_SW_NB;
          end else if (last_cell) begin
            state_nxt = sgs_pkg::ST_RESP;
          end else begin
            addr_nxt  = addr_r + AW'(1);
            x_nxt     = x_step;
            y_nxt     = y_step;
            state_nxt = sgs_pkg::ST_SW_RD;
          end
        end else if (last_cell) begin
          state_nxt = sgs_pkg::ST_RESP;
        end else begin
          // quiet cell: fetch the next one right away
          ram_re    = 1'b1;
          ram_raddr = addr_r + AW'(1);
          addr_nxt  = addr_r + AW'(1);
          x_nxt     = x_step;
          y_nxt     = y_step;
        end
      end

      sgs_pkg::ST_SW_NB: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr_r;
        ram_wdata = sgs_pkg::sat_inc(ram_rdata);
        if (nb_pend_r != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = pick_addr;
          nb_addr_nxt = pick_addr;
          nb_pend_nxt = nb_pend_r & ~pick_bit;
        end else if (last_cell) begin
          state_nxt = sgs_pkg::ST_RESP;
        end else begin
          // next read goes through ST_SW_RD: the last neighbor may be that cell
          addr_nxt  = addr_r + AW'(1);
          x_nxt     = x_step;
          y_nxt     = y_step;
          state_nxt = sgs_pkg::ST_SW_RD;
        end
      end

      sgs_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = sgs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sgs_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_height_r <= res_height_r;
      out_occ_r    <= (res_height_r != '0);
      out_count_r  <= count_r;
      out_oor_r    <= res_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_height  = out_height_r;
  assign out_occupied     = out_occ_r;
  assign out_topple_count = out_count_r;
  assign out_out_of_range = out_oor_r;

  // a cycle never reads the entry it writes
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // results only leave through the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sgs_pkg::ST_RESP))
    else $error("result appeared without a response step");

  // neighbor updates only follow a topple or another neighbor update
  a_nb_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgs_pkg::ST_SW_NB) |->
      ($past(state_r == sgs_pkg::ST_SW_CHK) || $past(state_r == sgs_pkg::ST_SW_NB)))
    else $error("neighbor update out of sequence");

  // a sweep transfer starts at the first cell
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == sgs_pkg::ACT_SWEEP)) |=>
      ((state_r == sgs_pkg::ST_SW_RD) && (addr_r == '0)))
    else $error("sweep did not start at the first cell");

endmodule

// File: tb/sgs_checker.sv
// sgs_checker: watches both channels of sandpile_grid_sweep, predicts each result
// from its own copy of the sand grid and compares field by field. Depends on sgs_pkg.
`timescale 1ns / 1ps

module sgs_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [sgs_pkg::ACTION_W-1:0] in_action,
  input  logic [sgs_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [sgs_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sgs_pkg::HEIGHT_W-1:0] out_cell_height,
  input  logic                         out_occupied,
  input  logic [sgs_pkg::COUNT_W-1:0]  out_topple_count,
  input  logic                         out_out_of_range,
  output int                           fail_count,
  output int                           reports_waiting
);

  typedef struct {
    logic [sgs_pkg::HEIGHT_W-1:0] height;
    logic                         occupied;
    logic [sgs_pkg::COUNT_W-1:0]  topples;
    logic                         off_grid;
  } cell_report_t;

  logic [sgs_pkg::HEIGHT_W-1:0] sand [0:sgs_pkg::CELLS-1];
  cell_report_t                 reports_due [$];
  int                           fails = 0;

  function automatic void drop_grain(int x, int y);
    int idx;
    idx = x * sgs_pkg::GRID_ROWS + y;
    if (sand[idx] != sgs_pkg::HEIGHT_MAX) sand[idx] = sand[idx] + 1'b1;
  endfunction

  // one raster pass, x outer, y inner; later cells see earlier gains
  function automatic logic [sgs_pkg::COUNT_W-1:0] topple_pass();
    int unsigned n;
    int          idx;
    n = 0;
    for (int x = 0; x < sgs_pkg::GRID_COLS; x++) begin
      for (int y = 0; y < sgs_pkg::GRID_ROWS; y++) begin
        idx = x * sgs_pkg::GRID_ROWS + y;
        if (sand[idx] >= sgs_pkg::TOPPLE_AT) begin
          sand[idx] = sand[idx] - sgs_pkg::TOPPLE_AT;
          if (y > 0) drop_grain(x, y - 1);
          if (y + 1 < sgs_pkg::GRID_ROWS) drop_grain(x, y + 1);
          if (x > 0) drop_grain(x - 1, y);
          if (x + 1 < sgs_pkg::GRID_COLS) drop_grain(x + 1, y);
          if (n < sgs_pkg::COUNT_MAX) n++;
        end
      end
    end
    return n[sgs_pkg::COUNT_W-1:0];
  endfunction

  function automatic cell_report_t predict_report(sgs_pkg::action_t act, int x, int y);
    cell_report_t r;
    int           idx;
    r = '{height: '0, occupied: 1'b0, topples: '0, off_grid: 1'b0};
    case (act)
      sgs_pkg::ACT_SWEEP: r.topples = topple_pass();
      sgs_pkg::ACT_ADD, sgs_pkg::ACT_READ: begin
        if (x >= sgs_pkg::GRID_COLS || y >= sgs_pkg::GRID_ROWS) begin
          r.off_grid = 1'b1;
        end else begin
          idx = x * sgs_pkg::GRID_ROWS + y;
          if (act == sgs_pkg::ACT_ADD) drop_grain(x, y);
          r.height   = sand[idx];
          r.occupied = (sand[idx] != '0);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cell_report_t want;
    if (!rst_n) begin
      // grid is all zero after reset
      for (int i = 0; i < sgs_pkg::CELLS; i++) sand[i] = '0;
      reports_due.delete();
    end else begin
      // retire first so a result is never matched with the item taken at this edge
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fails++;
        end else begin
          want = reports_due.pop_front();
          if (out_cell_height !== want.height) begin
            $error("cell_height: expected %0d, got %0d", want.height, out_cell_height);
            fails++;
          end
          if (out_occupied !== want.occupied) begin
            $error("occupied: expected %0d, got %0d", want.occupied, out_occupied);
            fails++;
          end
          if (out_topple_count !== want.topples) begin
            $error("topple_count: expected %0d, got %0d", want.topples, out_topple_count);
            fails++;
          end
          if (out_out_of_range !== want.off_grid) begin
            $error("out_of_range: expected %0d, got %0d", want.off_grid, out_out_of_range);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        reports_due.push_back(predict_report(sgs_pkg::action_t'(in_action),
                                             int'(in_cell_x), int'(in_cell_y)));
    end
    fail_count      <= fails;
    reports_waiting <= reports_due.size();
  end

endmodule

// File: tb/tb_sandpile_grid_sweep.sv
// tb_sandpile_grid_sweep: stimulus and verdict for sandpile_grid_sweep.
// Depends on sgs_pkg, the block itself and sgs_checker, which does all prediction.
`timescale 1ns / 1ps

module tb_sandpile_grid_sweep;

  localparam int CW = sgs_pkg::COORD_W;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [sgs_pkg::ACTION_W-1:0] in_action;
  logic [CW-1:0]                in_cell_x;
  logic [CW-1:0]                in_cell_y;
  logic                         out_valid;
  logic                         out_stall;
  logic [sgs_pkg::HEIGHT_W-1:0] out_cell_height;
  logic                         out_occupied;
  logic [sgs_pkg::COUNT_W-1:0]  out_topple_count;
  logic                         out_out_of_range;

  int fail_count;
  int reports_waiting;

  // sender burst bookkeeping
  int burst_left;
  // raised once by the stimulus to request the long receiver hold-off
  bit holdoff_go;
  // high while the receiver is in that hold-off
  bit holdoff_on;

  localparam logic [CW-1:0] EDGE_HI = CW'(sgs_pkg::GRID_COLS - 1);

  sandpile_grid_sweep dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_height  (out_cell_height),
    .out_occupied     (out_occupied),
    .out_topple_count (out_topple_count),
    .out_out_of_range (out_out_of_range)
  );

  sgs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_height  (out_cell_height),
    .out_occupied     (out_occupied),
    .out_topple_count (out_topple_count),
    .out_out_of_range (out_out_of_range),
    .fail_count       (fail_count),
    .reports_waiting  (reports_waiting)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit. Worst case is a few dozen sweeps where every cell topples,
  // plus the clearing pass; this is several times that.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stretches of differing stall density, including stall-free ones.
  // The first time holdoff_go is seen it holds off for a long count so the
  // output register and the sequencer both fill and in_stall backs up.
  initial begin
    int  run;
    int  pct;
    bit  held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (holdoff_go && !held) begin
        held = 1'b1;
        holdoff_on = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < 600; c++) @(posedge clk);
        holdoff_on = 1'b0;
      end
      run = $urandom_range(5, 80);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 60;
        default: pct = 90;
      endcase
      repeat (run) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  // One transfer on the input channel. Valid stays high across a burst; a gap
  // drops it first. Payload is held until the edge that takes it.
  task automatic send_item(input sgs_pkg::action_t act, input logic [CW-1:0] x,
                           input logic [CW-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_cell_x <= x;
    in_cell_y <= y;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // a coordinate one step off c at most, kept on the grid
  function automatic logic [CW-1:0] near(input logic [CW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > sgs_pkg::GRID_COLS - 1) v = sgs_pkg::GRID_COLS - 1;
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    logic [CW-1:0] c;
    case ($urandom_range(0, 3))
      0: c = '0;
      1: c = EDGE_HI;
      default: c = CW'($urandom_range(0, sgs_pkg::GRID_COLS - 1));
    endcase
    return c;
  endfunction

  initial begin
    int               counted;
    int               n_add;
    int               n_sw;
    int               n_rd;
    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    sgs_pkg::action_t act;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_action  <= sgs_pkg::ACT_NOP;
    in_cell_x  <= '0;
    in_cell_y  <= '0;
    burst_left = 0;
    holdoff_go = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fresh grid, the four corners, field extremes, the no-op code,
    // quiet sweep, toppling at a corner, an edge-free cell and the far corner.
    send_item(sgs_pkg::ACT_READ, '0, '0);
    send_item(sgs_pkg::ACT_ADD, '0, '0);
    send_item(sgs_pkg::ACT_ADD, EDGE_HI, EDGE_HI);
    send_item(sgs_pkg::ACT_ADD, '0, EDGE_HI);
    send_item(sgs_pkg::ACT_ADD, EDGE_HI, '0);
    send_item(sgs_pkg::ACT_READ, EDGE_HI, EDGE_HI);
    send_item(sgs_pkg::ACT_NOP, EDGE_HI, EDGE_HI);
    send_item(sgs_pkg::ACT_SWEEP, '0, '0);
    repeat (3) send_item(sgs_pkg::ACT_ADD, '0, '0);
    repeat (3) send_item(sgs_pkg::ACT_ADD, EDGE_HI, EDGE_HI);
    repeat (4) send_item(sgs_pkg::ACT_ADD, 6'd32, 6'd31);
    send_item(sgs_pkg::ACT_SWEEP, EDGE_HI, EDGE_HI);
    send_item(sgs_pkg::ACT_READ, 6'd0, 6'd1);
    send_item(sgs_pkg::ACT_READ, 6'd62, 6'd63);
    send_item(sgs_pkg::ACT_READ, 6'd32, 6'd32);
    send_item(sgs_pkg::ACT_SWEEP, 6'd42, 6'd21);
    send_item(sgs_pkg::ACT_READ, 6'd42, 6'd21);

    // Pressure: pile grains on (0,1) while the receiver holds off, then topple
    // (0,0) first in the pass so its grain lands on the pile.
    holdoff_go = 1'b1;
    wait (holdoff_on);
    repeat (8) send_item(sgs_pkg::ACT_ADD, 6'd0, 6'd1);
    send_item(sgs_pkg::ACT_READ, 6'd0, 6'd1);
    repeat (4) send_item(sgs_pkg::ACT_ADD, 6'd0, 6'd0);
    send_item(sgs_pkg::ACT_SWEEP, '0, '0);
    send_item(sgs_pkg::ACT_READ, 6'd0, 6'd1);
    send_item(sgs_pkg::ACT_READ, 6'd0, 6'd0);

    // Random: mostly hot spots (a cluster of adds, one or two sweeps, reads
    // nearby) so piles cascade, mixed with single random items as noise.
    counted = 0;
    while (counted < 60) begin
      if ($urandom_range(0, 9) < 7) begin
        cx = pick_coord();
        cy = pick_coord();
        n_add = $urandom_range(4, 14);
        n_sw  = $urandom_range(1, 2);
        n_rd  = $urandom_range(1, 3);
        repeat (n_add) send_item(sgs_pkg::ACT_ADD, near(cx), near(cy));
        repeat (n_sw) send_item(sgs_pkg::ACT_SWEEP, CW'($urandom), CW'($urandom));
        repeat (n_rd) send_item(sgs_pkg::ACT_READ, near(cx), near(cy));
        counted += n_add + n_sw + n_rd;
      end else begin
        act = sgs_pkg::action_t'($urandom_range(0, 3));
        send_item(act, CW'($urandom), CW'($urandom));
        counted++;
      end
    end
    in_valid <= 1'b0;

    // drain: the pending count is registered, so let it update before testing it
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
